FILE: hdl/gflz_pkg.sv
// ----------------------------------------------------------------------------
// gflz_pkg: shared types and constants for the GF(2^m) log/antilog unit
// Field widths, operation and status codes, config bundle, degree helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gflz_pkg;

  localparam int MAX_DEGREE  = 8;
  localparam int TABLE_DEPTH = 256;
  localparam int ELEM_W      = 8;
  localparam int POLY_W      = 9;
  localparam int MODE_W      = 3;
  localparam int STAT_W      = 2;
  localparam int DEG_W       = 4;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [POLY_W-1:0] POLY_RESET = 9'd285;

  // operation codes carried in the mode field
  typedef enum logic [MODE_W-1:0] {
    MODE_BUILD   = 3'd0,
    MODE_ADD     = 3'd1,
    MODE_MUL     = 3'd2,
    MODE_INV     = 3'd3,
    MODE_EXP_ADD = 3'd4,
    MODE_EXP_MUL = 3'd5,
    MODE_EXP_INV = 3'd6,
    MODE_RSVD    = 3'd7
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_BUILT = 2'd1,
    ST_INV_ZERO  = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  // register file to sequencer: current polynomial and write strobe
  typedef struct packed {
    logic [POLY_W-1:0] poly;
    logic              clear;
  } cfg_t;

  // index of the highest set bit above bit 0 (0 when poly <= 1)
  function automatic logic [DEG_W-1:0] poly_degree(input logic [POLY_W-1:0] p);
    logic [DEG_W-1:0] d;
    d = '0;
    for (int i = 1; i < POLY_W; i++) begin
      if (p[i]) d = DEG_W'(i);
    end
    return d;
  endfunction

  // 2^m - 1, which is also the zero code and the group order
  function automatic logic [ELEM_W-1:0] field_mask(input logic [DEG_W-1:0] m);
    logic [POLY_W-1:0] t;
    t = (POLY_W'(1) << m) - POLY_W'(1);
    return t[ELEM_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/gflz_if.sv
// ----------------------------------------------------------------------------
// gflz_if: valid/ready item channels of the GF(2^m) unit
// Request channel (mode, operands) and result channel (result, status).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gflz_in_if;
  import gflz_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ELEM_W-1:0] operand_a;
  logic [ELEM_W-1:0] operand_b;
  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface gflz_out_if;
  import gflz_pkg::*;
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] result;
  logic [STAT_W-1:0] status;
  modport source (output valid, result, status, input ready);
  modport sink   (input valid, result, status, output ready);
endinterface

`default_nettype wire

FILE: hdl/gflz_ram.sv
// ----------------------------------------------------------------------------
// gflz_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gflz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/gflz_modunit.sv
// ----------------------------------------------------------------------------
// gflz_modunit: shared modular adder over exponents
// r = (x + y') mod n1, y' = y or its negation mod n1; inputs at most n1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gflz_modunit (
  input  wire logic [gflz_pkg::ELEM_W-1:0] x,
  input  wire logic [gflz_pkg::ELEM_W-1:0] y,
  input  wire logic                        neg,
  input  wire logic [gflz_pkg::ELEM_W-1:0] n1,
  output logic      [gflz_pkg::ELEM_W-1:0] r
);
  import gflz_pkg::*;

  logic [ELEM_W-1:0] y_eff;
  logic [ELEM_W:0]   sum;
  logic [ELEM_W:0]   red;

  // negate: 0 and n1 both stand for exponent 0
  always_comb begin
    if (!neg) y_eff = y;
    else if (y == '0 || y == n1) y_eff = '0;
    else y_eff = n1 - y;
  end

  // one compare-subtract; sum of 2*n1 folds to 0
  always_comb begin
    sum = {1'b0, x} + {1'b0, y_eff};
    red = (sum >= {1'b0, n1}) ? sum - {1'b0, n1} : sum;
    r   = (red == {1'b0, n1}) ? '0 : red[ELEM_W-1:0];
  end

endmodule

`default_nettype wire

FILE: hdl/gflz_ctrl.sv
// ----------------------------------------------------------------------------
// gflz_ctrl: sequencer, tables and result register of the GF(2^m) unit
// Builds antilog/log/Zech tables and steps each item that needs them through
// table reads and the shared modular adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gflz_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire gflz_pkg::cfg_t              cfg,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [gflz_pkg::MODE_W-1:0] in_mode,
  input  wire logic [gflz_pkg::ELEM_W-1:0] in_a,
  input  wire logic [gflz_pkg::ELEM_W-1:0] in_b,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [gflz_pkg::ELEM_W-1:0] out_result,
  output logic      [gflz_pkg::STAT_W-1:0] out_status
);
  import gflz_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_CHECK  = 15'h0002,
    S_CLEAR  = 15'h0004,
    S_WALK   = 15'h0008,
    S_FIXUP  = 15'h0010,
    S_ZECH   = 15'h0020,
    S_ZDRAIN = 15'h0040,
    S_LA     = 15'h0080,
    S_LB     = 15'h0100,
    S_MIX    = 15'h0200,
    S_TAB    = 15'h0400,
    S_ZIDX   = 15'h0800,
    S_ZFIN   = 15'h1000,
    S_EXP    = 15'h2000,
    S_DONE   = 15'h4000
  } state_t;

  state_t            state;
  mode_t             mode_r;
  logic [ELEM_W-1:0] a_r;
  logic [ELEM_W-1:0] b_r;
  logic [ELEM_W-1:0] cnt;
  logic [ELEM_W-1:0] v;
  logic [ELEM_W-1:0] la;
  logic              zwr;
  logic [ELEM_W-1:0] zaddr;
  logic [ELEM_W-1:0] res_r;
  status_t           st_r;
  logic              tables_ready;

  // field geometry from the polynomial
  logic [DEG_W-1:0]  m;
  logic              poly_ok;
  logic [ELEM_W-1:0] n1;
  logic              a_oob;
  logic              b_oob;

  assign m       = poly_degree(cfg.poly);
  assign poly_ok = (m >= DEG_W'(2)) && (m <= DEG_W'(MAX_DEGREE));
  assign n1      = field_mask(m);
  assign a_oob   = (a_r & ~n1) != '0;
  assign b_oob   = (b_r & ~n1) != '0;

  // generator step: multiply by alpha and reduce
  logic [POLY_W-1:0] gen_w;
  logic [ELEM_W-1:0] v_step;
  always_comb begin
    gen_w = {v, 1'b0};
    if ((gen_w & (POLY_W'(1) << m)) != '0) gen_w = gen_w ^ cfg.poly;
    v_step = gen_w[ELEM_W-1:0] & n1;
  end

  // table ports
  logic              alog_we, log_we, zech_we;
  logic [ELEM_W-1:0] alog_waddr, alog_wdata, alog_raddr, alog_rdata;
  logic [ELEM_W-1:0] log_waddr, log_wdata, log_raddr, log_rdata;
  logic [ELEM_W-1:0] zech_waddr, zech_wdata, zech_raddr, zech_rdata;

  // shared adder operands
  logic [ELEM_W-1:0] ux, uy, unit_r;
  logic              uneg;

  gflz_modunit u_unit (
    .x   (ux),
    .y   (uy),
    .neg (uneg),
    .n1  (n1),
    .r   (unit_r)
  );

  gflz_ram #(.WIDTH(ELEM_W), .DEPTH(TABLE_DEPTH)) u_alog (
    .clk(clk), .we(alog_we), .waddr(alog_waddr), .wdata(alog_wdata),
    .raddr(alog_raddr), .rdata(alog_rdata)
  );

  gflz_ram #(.WIDTH(ELEM_W), .DEPTH(TABLE_DEPTH)) u_log (
    .clk(clk), .we(log_we), .waddr(log_waddr), .wdata(log_wdata),
    .raddr(log_raddr), .rdata(log_rdata)
  );

  gflz_ram #(.WIDTH(ELEM_W), .DEPTH(TABLE_DEPTH)) u_zech (
    .clk(clk), .we(zech_we), .waddr(zech_waddr), .wdata(zech_wdata),
    .raddr(zech_raddr), .rdata(zech_rdata)
  );

  // table addressing and adder operand select per state
  always_comb begin
    alog_we    = 1'b0;
    alog_waddr = '0;
    alog_wdata = '0;
    alog_raddr = '0;
    log_we     = 1'b0;
    log_waddr  = '0;
    log_wdata  = '0;
    log_raddr  = '0;
    zech_we    = 1'b0;
    zech_waddr = zaddr;
    zech_wdata = log_rdata;
    zech_raddr = '0;
    ux         = '0;
    uy         = '0;
    uneg       = 1'b0;
    case (state)
      S_CLEAR: begin
        log_we    = 1'b1;
        log_waddr = cnt;
      end
      S_WALK: begin
        alog_we    = 1'b1;
        alog_waddr = cnt;
        alog_wdata = v;
        log_we     = 1'b1;
        log_waddr  = v;
        log_wdata  = cnt;
      end
      S_FIXUP: begin
        alog_we    = 1'b1;
        alog_waddr = n1;
        log_we     = 1'b1;
        log_wdata  = n1;
      end
      S_ZECH: begin
        // last entry: antilog of the zero code is 0, so look up log(1)
        log_raddr = (cnt == n1) ? ELEM_W'(1) : ((v ^ ELEM_W'(1)) & n1);
        zech_we   = zwr;
      end
      S_ZDRAIN: zech_we = zwr;
      S_LA:     log_raddr = a_r;
      S_LB:     log_raddr = b_r;
      S_MIX: begin
        ux         = (mode_r == MODE_MUL) ? la : '0;
        uy         = log_rdata;
        uneg       = (mode_r == MODE_INV);
        alog_raddr = unit_r;
      end
      S_ZIDX: begin
        ux         = b_r;
        uy         = a_r;
        uneg       = 1'b1;
        zech_raddr = unit_r;
      end
      S_ZFIN: begin
        ux = a_r;
        uy = zech_rdata;
      end
      S_EXP: begin
        if (mode_r == MODE_EXP_MUL) begin
          ux = a_r;
          uy = b_r;
        end else begin
          uy   = a_r;
          uneg = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tables_ready <= 1'b0;
      out_valid    <= 1'b0;
      zwr          <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg.clear) tables_ready <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_r <= mode_t'(in_mode);
            a_r    <= in_a;
            b_r    <= in_b;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_r <= '0;
          st_r  <= ST_OK;
          state <= S_DONE;
          if (mode_r == MODE_BUILD) begin
            tables_ready <= 1'b0;
            if (!poly_ok) begin
              st_r <= ST_NOT_BUILT;
            end else begin
              cnt   <= '0;
              state <= S_CLEAR;
            end
          end else if (mode_r == MODE_RSVD) begin
            st_r <= ST_RANGE;
          end else if (!tables_ready || !poly_ok) begin
            st_r <= ST_NOT_BUILT;
          end else if (a_oob ||
                       (b_oob && mode_r != MODE_INV && mode_r != MODE_EXP_INV)) begin
            st_r <= ST_RANGE;
          end else begin
            case (mode_r)
              MODE_ADD: res_r <= a_r ^ b_r;
              MODE_MUL: begin
                if (a_r != '0 && b_r != '0) state <= S_LA;
              end
              MODE_INV: begin
                if (a_r == '0) st_r <= ST_INV_ZERO;
                else state <= S_LA;
              end
              MODE_EXP_ADD: begin
                if (a_r == n1) res_r <= b_r;
                else if (b_r == n1) res_r <= a_r;
                else if (a_r == b_r) res_r <= n1;
                else state <= S_ZIDX;
              end
              MODE_EXP_MUL: begin
                if (a_r == n1 || b_r == n1) res_r <= n1;
                else state <= S_EXP;
              end
              MODE_EXP_INV: begin
                if (a_r == n1) st_r <= ST_INV_ZERO;
                else state <= S_EXP;
              end
              default: ;
            endcase
          end
        end
        // zero the log entries of the field
        S_CLEAR: begin
          cnt <= cnt + ELEM_W'(1);
          if (cnt == n1) begin
            cnt   <= '0;
            v     <= ELEM_W'(1);
            state <= S_WALK;
          end
        end
        // walk alpha^0 .. alpha^(q-2)
        S_WALK: begin
          v   <= v_step;
          cnt <= cnt + ELEM_W'(1);
          if (cnt == n1 - ELEM_W'(1)) state <= S_FIXUP;
        end
        S_FIXUP: begin
          cnt   <= '0;
          v     <= ELEM_W'(1);
          zwr   <= 1'b0;
          state <= S_ZECH;
        end
        // rewalk and fill Zech entries, one log read in flight
        S_ZECH: begin
          zwr   <= 1'b1;
          zaddr <= cnt;
          v     <= v_step;
          cnt   <= cnt + ELEM_W'(1);
          if (cnt == n1) state <= S_ZDRAIN;
        end
        S_ZDRAIN: begin
          zwr          <= 1'b0;
          tables_ready <= 1'b1;
          state        <= S_DONE;
        end
        S_LA: state <= (mode_r == MODE_MUL) ? S_LB : S_MIX;
        S_LB: begin
          la    <= log_rdata;
          state <= S_MIX;
        end
        S_MIX: state <= S_TAB;
        S_TAB: begin
          res_r <= alog_rdata;
          state <= S_DONE;
        end
        S_ZIDX: state <= S_ZFIN;
        S_ZFIN: begin
          res_r <= (zech_rdata >= n1) ? n1 : unit_r;
          state <= S_DONE;
        end
        S_EXP: begin
          res_r <= unit_r;
          state <= S_DONE;
        end
        // hand the item to the output register once it is free
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            out_result <= (st_r == ST_OK) ? res_r : '0;
            out_status <= st_r;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_build_sets_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_ZDRAIN && !cfg.clear) |=> tables_ready)
    else $error("tables not marked ready after build");

  a_err_result_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_OK) |-> (out_result == '0))
    else $error("nonzero result with error status");

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_CHECK))
    else $error("accepted item did not enter check");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !out_ready) |=> (state == S_DONE))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

FILE: hdl/gf2m_log_zech_arith_unit_core.sv
// ----------------------------------------------------------------------------
// gf2m_log_zech_arith_unit_core: GF(2^m) log/antilog/Zech arithmetic unit
// APB field polynomial register plus sequencer over three table RAMs.
// ----------------------------------------------------------------------------
// Sequence: add, errors and special operands (zero, zero code) go from check to
// done; exp mul/inv pass S_EXP, exp add S_ZIDX and S_ZFIN, inv S_LA, S_MIX, S_TAB.
// Mul passes S_LA, S_LB, S_MIX and S_TAB. Build runs a clear pass, a generator
// walk, a fixup and a Zech pass; the passes handle one table entry per cycle.
// Items are taken one at a time; a held result register stalls input.
// Reset (rst, synchronous): tables not ready, polynomial 285; RAMs unset.
`timescale 1ns / 1ps
`default_nettype none

module gf2m_log_zech_arith_unit_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gflz_pkg::APB_AW-1:0] paddr,
  input  wire logic [gflz_pkg::APB_DW-1:0] pwdata,
  output logic      [gflz_pkg::APB_DW-1:0] prdata,
  output logic                             pready,
  gflz_in_if.sink                          in_ch,
  gflz_out_if.source                       out_ch
);
  import gflz_pkg::*;

  logic [POLY_W-1:0] field_poly;
  logic              hit;
  logic              wr;
  cfg_t              cfg;

  // register 0 decodes on paddr[2] == 0, so words 0 to 3 alias it; words 4 to 7 read 0, ignore writes
  assign pready = 1'b1;
  assign hit    = (paddr[APB_AW-1] == 1'b0);
  assign wr     = psel && penable && pwrite;
  assign prdata = hit ? {{(APB_DW-POLY_W){1'b0}}, field_poly} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_poly <= POLY_RESET;
    end else if (wr && hit) begin
      field_poly <= pwdata[POLY_W-1:0];
    end
  end

  assign cfg.poly  = field_poly;
  assign cfg.clear = wr && hit;

  gflz_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_mode    (in_ch.mode),
    .in_a       (in_ch.operand_a),
    .in_b       (in_ch.operand_b),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_result (out_ch.result),
    .out_status (out_ch.status)
  );

endmodule

`default_nettype wire

FILE: bench/gf2m_log_zech_arith_unit_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2m_log_zech_arith_unit_core_test: self-checking bench for the GF(2^m) unit
// Writes field polynomials over APB, builds the log/antilog/Zech tables and
// runs directed and random items through the request channel. Each result is
// checked against the value typed in its directed row or else a local table-based model.
// ----------------------------------------------------------------------------

module gf2m_log_zech_arith_unit_core_test;
  import gflz_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int END_WAIT       = 20;
  localparam int PHASE_ITEMS    = 70;
  localparam int NUM_PHASES     = 15;

  localparam logic [APB_AW-1:0] REG_FIELD_POLY = '0;

  // result item as the checker sees it
  typedef struct packed {
    logic [ELEM_W-1:0] result;
    status_t           status;
  } gf_result_t;

  // one row of the directed table
  typedef struct packed {
    logic              cfg;   // 1: write poly, 0: send an item
    logic [POLY_W-1:0] poly;
    mode_t             md;
    logic [ELEM_W-1:0] a;
    logic [ELEM_W-1:0] b;
    logic              chk;   // 1: expected result typed in the row
    logic [ELEM_W-1:0] res;
    status_t           st;
  } dir_row_t;

  localparam int NUM_DIRECTED = 28;
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    // reset polynomial 285, tables not built yet
    '{1'b0, 9'd0,   MODE_MUL,     8'd3,   8'd5,   1'b1, 8'd0,   ST_NOT_BUILT},
    '{1'b0, 9'd0,   MODE_RSVD,    8'd255, 8'd255, 1'b1, 8'd0,   ST_RANGE},
    '{1'b0, 9'd0,   MODE_BUILD,   8'd0,   8'd0,   1'b1, 8'd0,   ST_OK},
    '{1'b0, 9'd0,   MODE_ADD,     8'd255, 8'd255, 1'b1, 8'd0,   ST_OK},
    '{1'b0, 9'd0,   MODE_ADD,     8'd170, 8'd85,  1'b1, 8'd255, ST_OK},
    '{1'b0, 9'd0,   MODE_MUL,     8'd1,   8'd128, 1'b1, 8'd128, ST_OK},
    '{1'b0, 9'd0,   MODE_MUL,     8'd255, 8'd255, 1'b0, 8'd0,   ST_OK},
    '{1'b0, 9'd0,   MODE_INV,     8'd0,   8'd0,   1'b1, 8'd0,   ST_INV_ZERO},
    '{1'b0, 9'd0,   MODE_INV,     8'd1,   8'd255, 1'b1, 8'd1,   ST_OK},
    '{1'b0, 9'd0,   MODE_EXP_ADD, 8'd10,  8'd10,  1'b1, 8'd255, ST_OK},
    '{1'b0, 9'd0,   MODE_EXP_ADD, 8'd255, 8'd7,   1'b1, 8'd7,   ST_OK},
    '{1'b0, 9'd0,   MODE_EXP_MUL, 8'd254, 8'd254, 1'b1, 8'd253, ST_OK},
    '{1'b0, 9'd0,   MODE_EXP_INV, 8'd255, 8'd0,   1'b1, 8'd0,   ST_INV_ZERO},
    '{1'b0, 9'd0,   MODE_EXP_INV, 8'd254, 8'd0,   1'b1, 8'd1,   ST_OK},
    // GF(8): a write drops the tables, then operands outside the field
    '{1'b1, 9'd11,  MODE_BUILD,   8'd0,   8'd0,   1'b0, 8'd0,   ST_OK},
    '{1'b0, 9'd0,   MODE_MUL,     8'd2,   8'd3,   1'b1, 8'd0,   ST_NOT_BUILT},
    '{1'b0, 9'd0,   MODE_BUILD,   8'd0,   8'd0,   1'b1, 8'd0,   ST_OK},
    '{1'b0, 9'd0,   MODE_ADD,     8'd8,   8'd1,   1'b1, 8'd0,   ST_RANGE},
    '{1'b0, 9'd0,   MODE_EXP_INV, 8'd7,   8'd0,   1'b1, 8'd0,   ST_INV_ZERO},
    '{1'b0, 9'd0,   MODE_INV,     8'd9,   8'd0,   1'b1, 8'd0,   ST_RANGE},
    '{1'b0, 9'd0,   MODE_EXP_MUL, 8'd6,   8'd8,   1'b1, 8'd0,   ST_RANGE},
    // degree below 2: build refused
    '{1'b1, 9'd3,   MODE_BUILD,   8'd0,   8'd0,   1'b0, 8'd0,   ST_OK},
    '{1'b0, 9'd0,   MODE_BUILD,   8'd0,   8'd0,   1'b1, 8'd0,   ST_NOT_BUILT},
    '{1'b0, 9'd0,   MODE_ADD,     8'd0,   8'd0,   1'b1, 8'd0,   ST_NOT_BUILT},
    // x^2 is not primitive: tables follow the walk
    '{1'b1, 9'd4,   MODE_BUILD,   8'd0,   8'd0,   1'b0, 8'd0,   ST_OK},
    '{1'b0, 9'd0,   MODE_BUILD,   8'd0,   8'd0,   1'b1, 8'd0,   ST_OK},
    '{1'b0, 9'd0,   MODE_EXP_ADD, 8'd0,   8'd1,   1'b0, 8'd0,   ST_OK},
    '{1'b0, 9'd0,   MODE_MUL,     8'd2,   8'd2,   1'b0, 8'd0,   ST_OK}
  };

  // polynomials for the random phases; the last two phases pick one at random
  localparam logic [POLY_W-1:0] FIELD_POLYS [13] = '{
    9'd7, 9'd11, 9'd13, 9'd19, 9'd25, 9'd37, 9'd67,
    9'd131, 9'd137, 9'd285, 9'd299, 9'd511, 9'd301
  };
  localparam int PRESSURE_PHASE = 9;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  gflz_in_if  req_ch ();
  gflz_out_if res_ch ();

  gf2m_log_zech_arith_unit_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (req_ch.sink),
    .out_ch  (res_ch.source)
  );

  // field model state
  logic [POLY_W-1:0] fld_poly;
  bit                tables_built;
  logic [ELEM_W-1:0] alog_tab [TABLE_DEPTH];
  logic [ELEM_W-1:0] log_tab  [TABLE_DEPTH];
  logic [ELEM_W-1:0] zech_tab [TABLE_DEPTH];

  gf_result_t pending_results [$];

  // run control and bookkeeping
  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;
  bit hold_req  = 1'b0;
  int n_errors      = 0;
  int n_items       = 0;
  int n_builds      = 0;
  int n_poly_writes = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // field model
  // --------------------------------------------------------------------------

  // 2^m for a usable polynomial, 0 otherwise
  function automatic int field_order(input logic [POLY_W-1:0] p);
    int deg;
    deg = 0;
    for (int i = 1; i < POLY_W; i++)
      if (p[i]) deg = i;
    if (p < 4 || deg < 2 || deg > MAX_DEGREE) return 0;
    if ((1 << deg) > TABLE_DEPTH) return 0;
    return 1 << deg;
  endfunction

  // walk the generator, then derive the Zech logs
  function automatic bit build_field_tables();
    int q;
    int mask;
    int v;
    tables_built = 1'b0;
    q = field_order(fld_poly);
    if (q == 0) return 1'b0;
    mask = q - 1;
    for (int i = 0; i < q; i++) log_tab[i] = '0;
    alog_tab[0] = 8'd1;
    log_tab[1]  = 8'd0;
    for (int i = 1; i + 1 < q; i++) begin
      v = int'(alog_tab[i-1]) << 1;
      if ((v & q) != 0) v = v ^ int'(fld_poly);
      v = v & mask;
      alog_tab[i] = 8'(v);
      log_tab[v]  = 8'(i);
    end
    alog_tab[mask] = 8'd0;
    log_tab[0]     = 8'(mask);
    for (int i = 0; i < q; i++)
      zech_tab[i] = log_tab[(1 ^ int'(alog_tab[i])) & mask];
    tables_built = 1'b1;
    return 1'b1;
  endfunction

  function automatic gf_result_t compute_gf_result(input mode_t md,
                                                   input logic [ELEM_W-1:0] a_in,
                                                   input logic [ELEM_W-1:0] b_in);
    gf_result_t r;
    int q;
    int n1;
    int a;
    int b;
    int z;
    r.result = '0;
    r.status = ST_OK;
    a = int'(a_in);
    b = int'(b_in);
    q = field_order(fld_poly);
    if (md == MODE_BUILD) begin
      r.status = build_field_tables() ? ST_OK : ST_NOT_BUILT;
    end else if (md == MODE_RSVD) begin
      r.status = ST_RANGE;
    end else if (!tables_built || q == 0) begin
      r.status = ST_NOT_BUILT;
    end else begin
      n1 = q - 1;
      if (a >= q || (md != MODE_INV && md != MODE_EXP_INV && b >= q)) begin
        r.status = ST_RANGE;
      end else begin
        case (md)
          MODE_ADD: begin
            r.result = a_in ^ b_in;
          end
          MODE_MUL: begin
            if (a != 0 && b != 0)
              r.result = alog_tab[(int'(log_tab[a]) + int'(log_tab[b])) % n1];
          end
          MODE_INV: begin
            if (a == 0) r.status = ST_INV_ZERO;
            else r.result = alog_tab[(n1 - int'(log_tab[a]) % n1) % n1];
          end
          MODE_EXP_ADD: begin
            // Zech addition; the zero code is the identity
            if (a == n1) r.result = b_in;
            else if (b == n1) r.result = a_in;
            else if (a == b) r.result = 8'(n1);
            else begin
              z = int'(zech_tab[(n1 + b - a) % n1]);
              r.result = (z >= n1) ? 8'(n1) : 8'((a + z) % n1);
            end
          end
          MODE_EXP_MUL: begin
            r.result = (a == n1 || b == n1) ? 8'(n1) : 8'((a + b) % n1);
          end
          default: begin
            if (a == n1) r.status = ST_INV_ZERO;
            else r.result = 8'((n1 - a) % n1);
          end
        endcase
      end
    end
    if (r.status != ST_OK) r.result = '0;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------

  task automatic report_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one item; returns at the edge where it is accepted
  task automatic send_item(input mode_t md, input logic [ELEM_W-1:0] a,
                           input logic [ELEM_W-1:0] b, input bit typed,
                           input gf_result_t typed_exp);
    int gap;
    gf_result_t model_exp;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.mode      <= md;
    req_ch.operand_a <= a;
    req_ch.operand_b <= b;
    do @(posedge clk); while (!req_ch.ready);
    model_exp = compute_gf_result(md, a, b);
    pending_results.push_back(typed ? typed_exp : model_exp);
    n_items++;
    if (md == MODE_BUILD) n_builds++;
  endtask

  // stop offering and wait for every result to come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB write of the polynomial, then read it back
  task automatic write_poly(input logic [POLY_W-1:0] p);
    logic [APB_DW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_FIELD_POLY;
    pwdata  <= APB_DW'(p);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    fld_poly     = p;
    tables_built = 1'b0;
    n_poly_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[POLY_W-1:0] !== p)
      report_error($sformatf("poly readback: expected %0d, got %0d", p, rd[POLY_W-1:0]));
  endtask

  function automatic logic [ELEM_W-1:0] pick_operand(input mode_t md, input int q);
    int r;
    bit exp_form;
    exp_form = (md == MODE_EXP_ADD || md == MODE_EXP_MUL || md == MODE_EXP_INV);
    r = $urandom_range(0, 99);
    if (r < 12) return exp_form ? 8'(q - 1) : 8'd0;
    if (r < 18) return exp_form ? 8'd0 : 8'(q - 1);
    if (r < 22) return 8'd1;
    return 8'($urandom_range(0, q - 1));
  endfunction

  task automatic send_random_item();
    int q;
    int r;
    mode_t md;
    logic [ELEM_W-1:0] a;
    logic [ELEM_W-1:0] b;
    q = field_order(fld_poly);
    if (q == 0) q = TABLE_DEPTH;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      md = MODE_RSVD;
      a  = 8'($urandom_range(0, 255));
      b  = 8'($urandom_range(0, 255));
    end else if (r < 5) begin
      md = MODE_BUILD;
      a  = 8'($urandom_range(0, 255));
      b  = 8'($urandom_range(0, 255));
    end else begin
      md = mode_t'($urandom_range(1, 6));
      a  = pick_operand(md, q);
      if (md == MODE_INV || md == MODE_EXP_INV) b = 8'($urandom_range(0, 255));
      else if (md == MODE_EXP_ADD && $urandom_range(0, 9) == 0) b = a;
      else b = pick_operand(md, q);
      // operand beyond the field
      if (r < 11 && q < TABLE_DEPTH) begin
        if ($urandom_range(0, 1) == 0) a = 8'($urandom_range(q, 255));
        else b = 8'($urandom_range(q, 255));
      end
    end
    send_item(md, a, b, 1'b0, '0);
  endtask

  // one polynomial setting: a few items unbuilt, a build, then mixed traffic
  task automatic run_field_phase(input logic [POLY_W-1:0] p, input bit pressure);
    drain();
    write_poly(p);
    repeat (2) send_random_item();
    send_item(MODE_BUILD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              1'b0, '0);
    if (pressure) hold_req = 1'b1;
    repeat (PHASE_ITEMS) send_random_item();
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [POLY_W-1:0] p;
    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.mode      <= '0;
    req_ch.operand_a <= '0;
    req_ch.operand_b <= '0;
    fld_poly     = POLY_RESET;
    tables_built = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED[i].cfg) begin
        drain();
        write_poly(DIRECTED[i].poly);
      end else begin
        send_item(DIRECTED[i].md, DIRECTED[i].a, DIRECTED[i].b, DIRECTED[i].chk,
                  '{DIRECTED[i].res, DIRECTED[i].st});
      end
    end

    // random phases; the first runs with no idling on either side
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      gaps_on   = (ph != 0) && ($urandom_range(0, 3) != 0);
      stalls_on = (ph != 0) && ($urandom_range(0, 3) != 0);
      p = (ph < 13) ? FIELD_POLYS[ph] : POLY_W'($urandom_range(4, 511));
      run_field_phase(p, ph == PRESSURE_PHASE);
    end

    drain();
    repeat (END_WAIT) @(posedge clk);
    $display("Ran %0d items across %0d polynomial writes with %0d table builds",
             n_items, n_poly_writes, n_builds);
    $display("Status mix: ok %0d, not built %0d, inverse of zero %0d, out of field %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d errors", n_errors);
      $display("Regression FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // result side: random stalls plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int n;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = stalls_on ? pick_gap() : 0;
        res_ch.ready <= (n == 0);
        repeat ((n == 0) ? 1 : n) @(posedge clk);
      end
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk) begin : result_check
    gf_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      status_seen[res_ch.status]++;
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected result %0d status %0d",
                               res_ch.result, res_ch.status));
      end else begin
        want = pending_results.pop_front();
        if (res_ch.result !== want.result || res_ch.status !== want.status)
          report_error($sformatf("expected result %0d status %0d, got result %0d status %0d",
                                 want.result, want.status, res_ch.result, res_ch.status));
      end
    end
  end

  // end the run if nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hdl/gflz_pkg.sv
hdl/gflz_if.sv
hdl/gflz_ram.sv
hdl/gflz_modunit.sv
hdl/gflz_ctrl.sv
hdl/gf2m_log_zech_arith_unit_core.sv
bench/gf2m_log_zech_arith_unit_core_test.sv
